// ----- src/mhtq_pkg.sv -----
// Shared types and codes for the min-heap timer queue.
package mhtq_pkg;
  localparam int ID_W   = 10;
  localparam int IN_T_W = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_POP    = 2'd1,
    OP_ADJUST = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;
endpackage

// ----- src/mhtq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module mhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/min_heap_timer_queue.sv -----
// Top level of the min-heap timer queue: sequencer, entry RAM and output register.
//
// Binary min-heap of {id, expiry} held in one RAM (CAPACITY words), walked by a
// small sequencer. RAM reads are registered: the data is used in the state after
// the one that gives the address. Sift up reads the parent and compares, level by
// level; sift down reads the left child, then the right child, and compares.
// Adjust searches the entries one by one, then sifts down if the new expiry is
// later. A tick pops each expired root in turn. in_ready is low while an operation
// is in flight and while a result word waits in the output register. Each result
// word sits there until taken. A tick holds each popped id back until the next
// root is checked, so last can be set on the final one; the next pop waits until
// the earlier word is taken. No clearing pass after reset: only the first count
// entries are ever used.
module min_heap_timer_queue #(
  parameter int CAPACITY  = 64,
  parameter int TIME_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_opcode,
  input  logic [mhtq_pkg::ID_W-1:0]  in_timer_id,
  input  logic [mhtq_pkg::IN_T_W-1:0] in_expire_time,
  input  logic [mhtq_pkg::IN_T_W-1:0] in_now_time,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic                       out_out_valid,
  output logic [mhtq_pkg::ID_W-1:0]  out_out_id,
  output logic                       out_last
);
  import mhtq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = AW + 2;  // child index, wide enough for 2*pos+2
  localparam int EW = ID_W + TIME_BITS;
  localparam int TW = (TIME_BITS < IN_T_W) ? TIME_BITS : IN_T_W;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_UPRD  = 13'b0000000000010, // read parent
    S_UPCMP = 13'b0000000000100,
    S_POPRD = 13'b0000000001000, // read root
    S_DNRD  = 13'b0000000010000, // read left child
    S_DNRD2 = 13'b0000000100000, // read right child, latch left
    S_DNCMP = 13'b0000001000000,
    S_SRRD  = 13'b0000010000000, // search read
    S_SRCMP = 13'b0000100000000,
    S_OUT   = 13'b0001000000000,
    S_TICKR = 13'b0010000000000, // read root for tick
    S_TICKC = 13'b0100000000000,
    S_POPL  = 13'b1000000000000  // latch root id, read last entry
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] pos_r, pos_nxt, idx_r, idx_nxt;
  logic [ID_W-1:0] hid_r, hid_nxt, id_q_r, id_q_nxt;
  logic [TIME_BITS-1:0] hwhen_r, hwhen_nxt, now_r, now_nxt;
  logic [EW-1:0] kid_r, kid_nxt;
  logic [AW-1:0] kpos_r, kpos_nxt;
  logic [1:0] op_r, op_nxt;
  logic tick_any_r, tick_any_nxt;

  logic ov_r, ov_nxt;
  logic [1:0] st_r, st_nxt;
  logic oval_r, oval_nxt, olast_r, olast_nxt;
  logic [ID_W-1:0] oid_r, oid_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  mhtq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [ID_W-1:0]      r_id;
  logic [TIME_BITS-1:0] r_when, k_when;
  logic [TIME_BITS-1:0] in_exp_t, in_now_t;
  logic [KW-1:0] l_kid, r_kid, pos_c, count_k;

  assign r_id    = rdata[EW-1 -: ID_W];
  assign r_when  = rdata[TIME_BITS-1:0];
  assign k_when  = kid_r[TIME_BITS-1:0];
  assign pos_c   = KW'(pos_r);
  assign count_k = KW'(count_r);
  assign l_kid   = {pos_c[KW-2:0], 1'b1};
  assign r_kid   = l_kid + KW'(1);

  always_comb begin
    in_exp_t = '0;
    in_now_t = '0;
    in_exp_t[TW-1:0] = in_expire_time[TW-1:0];
    in_now_t[TW-1:0] = in_now_time[TW-1:0];
  end

  assign in_ready = (state_r == S_IDLE) && !ov_r;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; pos_nxt = pos_r; idx_nxt = idx_r;
    hid_nxt = hid_r; hwhen_nxt = hwhen_r; now_nxt = now_r; kid_nxt = kid_r;
    kpos_nxt = kpos_r; op_nxt = op_r; id_q_nxt = id_q_r;
    tick_any_nxt = tick_any_r;
    ov_nxt = ov_r; st_nxt = st_r; oval_nxt = oval_r; oid_nxt = oid_r; olast_nxt = olast_r;
    we = 1'b0; waddr = pos_r; wdata = {hid_r, hwhen_r}; raddr = pos_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt = in_opcode; id_q_nxt = in_timer_id;
          hid_nxt = in_timer_id; hwhen_nxt = in_exp_t; now_nxt = in_now_t;
          tick_any_nxt = 1'b0;
          case (op_t'(in_opcode))
            OP_ADD: begin
              if (count_r >= CW'(CAPACITY)) begin
                st_nxt = ST_FULL; oval_nxt = 1'b0; oid_nxt = '0; olast_nxt = 1'b1;
                ov_nxt = 1'b1;
              end else begin
                pos_nxt = AW'(count_r); count_nxt = count_r + CW'(1);
                state_nxt = S_UPRD;
              end
            end
            OP_POP, OP_TICK: begin
              if (count_r == '0) begin
                st_nxt = ST_EMPTY; oval_nxt = 1'b0; oid_nxt = '0; olast_nxt = 1'b1;
                ov_nxt = 1'b1;
              end else begin
                state_nxt = (op_t'(in_opcode) == OP_POP) ? S_POPRD : S_TICKR;
              end
            end
            OP_ADJUST: begin
              if (count_r == '0) begin
                st_nxt = ST_NOTFOUND; oval_nxt = 1'b0; oid_nxt = '0; olast_nxt = 1'b1;
                ov_nxt = 1'b1;
              end else begin
                idx_nxt = '0; state_nxt = S_SRRD;
              end
            end
            default: ;
          endcase
        end
      end
      // sift up: hole at pos_r, held entry in hid/hwhen
      S_UPRD: begin
        if (pos_r == '0) begin
          we = 1'b1;
          st_nxt = ST_OK; oval_nxt = 1'b0; oid_nxt = '0; olast_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          raddr = AW'((pos_r - AW'(1)) >> 1);
          kpos_nxt = raddr;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (r_when > hwhen_r) begin
          we = 1'b1; wdata = rdata; pos_nxt = kpos_r; state_nxt = S_UPRD;
        end else begin
          we = 1'b1;
          st_nxt = ST_OK; oval_nxt = 1'b0; oid_nxt = '0; olast_nxt = 1'b1;
          state_nxt = S_OUT;
        end
      end
      // pop root: report root id, pull last entry into hole at root
      S_POPRD: begin
        raddr = '0;
        state_nxt = S_POPL;
      end
      S_POPL: begin
        raddr = '0;  // keep the root on rdata while the last tick word waits
        if (!ov_nxt) begin
          oid_nxt = r_id; oval_nxt = 1'b1; st_nxt = ST_OK;
          olast_nxt = (op_r == OP_POP);
          tick_any_nxt = 1'b1;
          count_nxt = count_r - CW'(1);
          raddr = AW'(count_r - CW'(1));
          pos_nxt = '0;
          state_nxt = S_DNRD;
          kpos_nxt = '1;  // marker: held not yet latched
        end
      end
      S_DNRD: begin
        if (kpos_r == '1 && op_r != OP_ADJUST) begin
          hid_nxt = r_id; hwhen_nxt = r_when;
          kpos_nxt = '0;
        end
        if (count_nxt == '0 || (kpos_r == '1 && op_r != OP_ADJUST && count_r == '0)) begin
          state_nxt = S_OUT;
        end else if (l_kid >= count_k) begin
          we = 1'b1;
          if (kpos_r == '1 && op_r != OP_ADJUST) wdata = rdata;
          state_nxt = S_OUT;
        end else begin
          raddr = AW'(l_kid);
          state_nxt = S_DNRD2;
        end
      end
      S_DNRD2: begin
        kid_nxt = rdata; kpos_nxt = AW'(l_kid);
        raddr = AW'(r_kid);
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (r_kid < count_k && k_when > r_when) begin
          if (hwhen_r > r_when) begin
            we = 1'b1; wdata = rdata; pos_nxt = AW'(r_kid); kpos_nxt = '0;
            state_nxt = S_DNRD;
          end else begin
            we = 1'b1; state_nxt = S_OUT;
          end
        end else if (hwhen_r > k_when) begin
          we = 1'b1; wdata = kid_r; pos_nxt = kpos_r; kpos_nxt = '0;
          state_nxt = S_DNRD;
        end else begin
          we = 1'b1; state_nxt = S_OUT;
        end
      end
      // adjust: linear search from idx 0
      S_SRRD: begin
        raddr = idx_r;
        state_nxt = S_SRCMP;
      end
      S_SRCMP: begin
        if (r_id == id_q_r) begin
          if (hwhen_r > r_when) begin
            hid_nxt = r_id; pos_nxt = idx_r; kpos_nxt = '0;
            state_nxt = S_DNRD;
          end else begin
            state_nxt = S_OUT;
          end
          st_nxt = ST_OK; oval_nxt = 1'b0; oid_nxt = '0; olast_nxt = 1'b1;
        end else if (CW'(idx_r) + CW'(1) >= count_r) begin
          st_nxt = ST_NOTFOUND; oval_nxt = 1'b0; oid_nxt = '0; olast_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + AW'(1); state_nxt = S_SRRD;
        end
      end
      S_OUT: begin
        if (op_r == OP_TICK) begin
          state_nxt = S_TICKR;
        end else begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_TICKR: begin
        raddr = '0;
        if (count_r == '0) begin
          // heap drained: the held id is the final word
          if (!ov_nxt) begin
            olast_nxt = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_TICKC;
        end
      end
      S_TICKC: begin
        raddr = '0;
        if (r_when <= now_r) begin
          // another root expires: release the held id with last low
          if (tick_any_r) begin
            olast_nxt = 1'b0; ov_nxt = 1'b1;
          end
          state_nxt = S_POPL;
        end else if (!ov_nxt) begin
          if (tick_any_r) begin
            olast_nxt = 1'b1;
          end else begin
            st_nxt = ST_OK; oval_nxt = 1'b0; oid_nxt = '0; olast_nxt = 1'b1;
          end
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Tick results are held back one step: a popped id goes out only once the
  // next root is checked or the heap is drained, so last can be set on it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
    pos_r <= pos_nxt; idx_r <= idx_nxt; hid_r <= hid_nxt; hwhen_r <= hwhen_nxt;
    now_r <= now_nxt; kid_r <= kid_nxt; kpos_r <= kpos_nxt; op_r <= op_nxt;
    id_q_r <= id_q_nxt; tick_any_r <= tick_any_nxt;
    st_r <= st_nxt; oval_r <= oval_nxt; oid_r <= oid_nxt; olast_r <= olast_nxt;
  end

  assign out_valid     = ov_r;
  assign out_status    = st_r;
  assign out_out_valid = oval_r;
  assign out_out_id    = oid_r;
  assign out_last      = olast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("entry count over capacity");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_out_id)))
    else $error("result word dropped");
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the min-heap timer queue: directed table, random traffic, predictor check.
module tb_top;
  import mhtq_pkg::*;

  localparam int CAP      = 64;
  localparam int N_RAND   = 350;
  localparam int WD_LIMIT = 20000;  // idle cycles allowed before giving up

  // one expected result word
  typedef struct packed {
    status_t          st;
    logic             hit;
    logic [ID_W-1:0]  id;
    logic             lst;
  } result_word_t;

  // one directed row; chk means the typed-in result word is also compared
  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [31:0]      exp_t;
    logic [31:0]      now_t;
    logic             chk;
    result_word_t     want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [ID_W-1:0] in_timer_id = '0;
  logic [IN_T_W-1:0] in_expire_time = '0;
  logic [IN_T_W-1:0] in_now_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic out_out_valid;
  logic [ID_W-1:0] out_out_id;
  logic out_last;

  always #5 clk = ~clk;

  min_heap_timer_queue #(.CAPACITY(CAP), .TIME_BITS(32)) u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_timer_id,
    .in_expire_time, .in_now_time, .out_valid, .out_ready, .out_status,
    .out_out_valid, .out_out_id, .out_last
  );

  // ---- predictor state: our own copy of the heap ----
  logic [ID_W-1:0] heap_id [CAP];
  logic [31:0]     heap_due [CAP];
  int              heap_cnt = 0;

  result_word_t pending_words[$];
  int  n_bad = 0;
  int  idle_cycles = 0;
  bit  rx_hold = 1'b0;       // long receiver hold-off in progress
  bit  stim_done = 1'b0;

  function automatic void queue_word(result_word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  // move the entry at pos down until neither child is earlier
  function automatic void sift_down(int pos);
    logic [ID_W-1:0] hid;
    logic [31:0] hdue;
    int kid;
    hid = heap_id[pos];
    hdue = heap_due[pos];
    while (2 * pos + 1 < heap_cnt) begin
      kid = 2 * pos + 1;
      if (kid + 1 < heap_cnt && heap_due[kid] > heap_due[kid + 1]) kid++;
      if (hdue > heap_due[kid]) begin
        heap_id[pos] = heap_id[kid];
        heap_due[pos] = heap_due[kid];
        pos = kid;
      end else break;
    end
    heap_id[pos] = hid;
    heap_due[pos] = hdue;
  endfunction

  function automatic void sift_up(int pos);
    logic [ID_W-1:0] hid;
    logic [31:0] hdue;
    int up;
    hid = heap_id[pos];
    hdue = heap_due[pos];
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (heap_due[up] > hdue) begin
        heap_id[pos] = heap_id[up];
        heap_due[pos] = heap_due[up];
        pos = up;
      end else break;
    end
    heap_id[pos] = hid;
    heap_due[pos] = hdue;
  endfunction

  function automatic logic [ID_W-1:0] remove_root();
    logic [ID_W-1:0] rid;
    rid = heap_id[0];
    heap_cnt--;
    if (heap_cnt > 0) begin
      heap_id[0] = heap_id[heap_cnt];
      heap_due[0] = heap_due[heap_cnt];
      sift_down(0);
    end
    return rid;
  endfunction

  function automatic result_word_t mk(status_t s, logic h, logic [ID_W-1:0] i, logic l);
    result_word_t w;
    w.st = s; w.hit = h; w.id = i; w.lst = l;
    return w;
  endfunction

  // apply one accepted word to the heap and queue the results it causes
  function automatic void predict_timer_op(op_t op, logic [ID_W-1:0] id,
                                           logic [31:0] et, logic [31:0] nt);
    int n;
    bit found;
    result_word_t prev;
    n = 0;
    found = 1'b0;
    prev = '0;
    case (op)
      OP_ADD: begin
        if (heap_cnt >= CAP) queue_word(mk(ST_FULL, 0, '0, 1));
        else begin
          heap_id[heap_cnt] = id;
          heap_due[heap_cnt] = et;
          heap_cnt++;
          sift_up(heap_cnt - 1);
          queue_word(mk(ST_OK, 0, '0, 1));
        end
      end
      OP_POP: begin
        if (heap_cnt == 0) queue_word(mk(ST_EMPTY, 0, '0, 1));
        else queue_word(mk(ST_OK, 1, remove_root(), 1));
      end
      OP_ADJUST: begin
        for (int i = 0; i < heap_cnt && !found; i++) begin
          if (heap_id[i] == id) begin
            found = 1'b1;
            if (et > heap_due[i]) begin
              heap_due[i] = et;
              sift_down(i);
            end
          end
        end
        queue_word(mk(found ? ST_OK : ST_NOTFOUND, 0, '0, 1));
      end
      default: begin
        if (heap_cnt == 0) queue_word(mk(ST_EMPTY, 0, '0, 1));
        else begin
          // each popped id is queued once the next one is known
          while (heap_cnt > 0 && heap_due[0] <= nt) begin
            if (n > 0) queue_word(prev);
            prev = mk(ST_OK, 1, remove_root(), 0);
            n++;
          end
          if (n == 0) queue_word(mk(ST_OK, 0, '0, 1));
          else begin
            prev.lst = 1'b1;
            queue_word(prev);
          end
        end
      end
    endcase
  endfunction

  // directed rows (typed result only where it's obvious)
  row_t dir_rows[$];
  function automatic void add_row(op_t op, logic [ID_W-1:0] id, logic [31:0] et,
                                  logic [31:0] nt, logic chk, result_word_t w);
    row_t r;
    r.op = op; r.id = id; r.exp_t = et; r.now_t = nt; r.chk = chk; r.want = w;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  result_word_t typed_q[$];  // typed expectations for all rows; the parallel flag below marks the checked ones
  bit typed_flag[$];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(op_t op, logic [ID_W-1:0] id, logic [31:0] et, logic [31:0] nt);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_timer_id <= id;
    in_expire_time <= et;
    in_now_time <= nt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_timer_op(op, id, et, nt);
    @(negedge clk);
  endtask

  task automatic idle_gap(int g);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // ---- stimulus ----
  initial begin
    op_t op;
    logic [ID_W-1:0] id;
    logic [31:0] et, nt;
    int r;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty-heap cases, extremes, ties, duplicates, adjust not-later
    add_row(OP_POP, 0, 0, 0, 1, mk(ST_EMPTY, 0, '0, 1));
    add_row(OP_TICK, 0, 0, 32'hFFFF_FFFF, 1, mk(ST_EMPTY, 0, '0, 1));
    add_row(OP_ADJUST, 10'h3FF, 32'hFFFF_FFFF, 0, 1, mk(ST_NOTFOUND, 0, '0, 1));
    add_row(OP_ADD, 10'h3FF, 32'hFFFF_FFFF, 0, 1, mk(ST_OK, 0, '0, 1));
    add_row(OP_ADD, 0, 0, 0, 1, mk(ST_OK, 0, '0, 1));
    add_row(OP_ADD, 5, 100, 0, 0, '0);
    add_row(OP_ADD, 6, 100, 0, 0, '0);
    add_row(OP_ADD, 5, 50, 0, 0, '0);
    add_row(OP_ADJUST, 5, 10, 0, 0, '0);
    add_row(OP_ADJUST, 5, 200, 0, 0, '0);
    add_row(OP_TICK, 0, 0, 99, 0, '0);
    add_row(OP_TICK, 0, 0, 0, 0, '0);
    add_row(OP_POP, 0, 0, 0, 0, '0);
    add_row(OP_TICK, 0, 0, 32'hFFFF_FFFF, 0, '0);
    add_row(OP_TICK, 0, 0, 5, 1, mk(ST_EMPTY, 0, '0, 1));
    foreach (dir_rows[i]) begin
      typed_q.insert(typed_q.size(), dir_rows[i].want);
      typed_flag.insert(typed_flag.size(), dir_rows[i].chk);
      send_word(dir_rows[i].op, dir_rows[i].id, dir_rows[i].exp_t, dir_rows[i].now_t);
      idle_gap(pick_gap());
    end
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    typed_q.delete();
    typed_flag.delete();

    // fill to capacity while the receiver holds off, then one add past full
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
      end
    join_none
    for (int i = 0; i <= CAP; i++)
      send_word(OP_ADD, ID_W'($urandom_range(0, 1023)), $urandom, 0);
    idle_gap(1);
    while (pending_words.size() != 0) @(negedge clk);
    send_word(OP_TICK, 0, 0, 32'hFFFF_FFFF);   // drains all 64 in one tick

    // random: mostly adds and ticks with close times so roots expire in batches
    nt = 0;
    for (int k = 0; k < N_RAND; k++) begin
      r = $urandom_range(0, 99);
      id = (r & 1) ? ID_W'($urandom_range(0, 1023)) : ID_W'($urandom_range(0, 15));
      if (r < 45) begin op = OP_ADD; et = nt + $urandom_range(0, 300); end
      else if (r < 60) begin op = OP_POP; et = $urandom; end
      else if (r < 75) begin op = OP_ADJUST; et = nt + $urandom_range(0, 400); end
      else begin op = OP_TICK; et = $urandom; end
      if ($urandom_range(0, 19) == 0) et = $urandom;
      if (op == OP_TICK) nt = nt + $urandom_range(0, 120);
      send_word(op, id, et, (op == OP_TICK) ? nt : $urandom);
      if (k == N_RAND / 2) begin
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
      end
      idle_gap(pick_gap());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stalls
  always @(negedge clk) begin
    if (!rst_n || rx_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) < 12) ? 1'b0 :
                      ($urandom_range(0, 99) < 3) ? 1'b0 : 1'b1;
  end

  // output checker
  always @(posedge clk) begin
    result_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result word st=%0d id=%0d", out_status, out_out_id);
      end else begin
        w = pending_words.pop_front();
        if (typed_flag.size() != 0 && out_last) begin
          if (typed_flag[0] && typed_q[0] != w) begin
            n_bad++;
            if (n_bad <= 10) $display("directed row disagrees with predictor");
          end
          void'(typed_q.pop_front());
          void'(typed_flag.pop_front());
        end
        if (out_status != w.st || out_out_valid != w.hit || out_out_id != w.id ||
            out_last != w.lst) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp st=%0d v=%0d id=%0d last=%0d got st=%0d v=%0d id=%0d last=%0d",
                     w.st, w.hit, w.id, w.lst, out_status, out_out_valid, out_out_id, out_last);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (pending_words.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (n_bad == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
